>>> rtl/child_to_parent_index_mapper_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the child-to-parent index mapper
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef CHILD_TO_PARENT_INDEX_MAPPER_TOP_MACROS_SVH
`define CHILD_TO_PARENT_INDEX_MAPPER_TOP_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset
`define CPIM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("cpim assertion failed");
// Next-cycle implication, disabled during reset
`define CPIM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("cpim assertion failed");
`else
`define CPIM_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define CPIM_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> rtl/cpim_pkg.sv
// ----------------------------------------------------------------------------
// cpim_pkg
// Shared constants and types of the child-to-parent index mapper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cpim_pkg;

  // Sizes
  localparam int unsigned PARENT_DEPTH = 1024;
  localparam int unsigned IDX_W        = 32;
  localparam int unsigned ADDR_W       = $clog2(PARENT_DEPTH);
  localparam int unsigned LEN_W        = $clog2(PARENT_DEPTH + 1);
  localparam int unsigned HITS_W       = 11;
  localparam int unsigned CMD_W        = 2;
  localparam int unsigned CFG_IDX_W    = 1;

  localparam logic [HITS_W-1:0] HITS_MAX = {HITS_W{1'b1}};
  localparam logic [LEN_W-1:0]  LEN_FULL = LEN_W'(PARENT_DEPTH);

  // Command codes on the input port
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MAP    = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SEP_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEP_END   = 1'b1;

  // Classified operation handed from front to back
  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_MAP    = 2'd2
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [IDX_W-1:0] value;
    logic             last;
  } q_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] sep_start;
    logic [IDX_W-1:0] sep_end;
  } cfg_t;

endpackage

>>> rtl/cpim_front.sv
// ----------------------------------------------------------------------------
// cpim_front
// Accepts command beats, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "child_to_parent_index_mapper_top_macros.svh"

module cpim_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [cpim_pkg::CMD_W-1:0]  command_i,
  input  logic [cpim_pkg::IDX_W-1:0]  value_i,
  input  logic                        last_i,
  output logic                        busy_o,
  output logic                        item_valid_o,
  output cpim_pkg::q_item_t           item_o,
  input  logic                        pop_i
);

  cpim_pkg::q_item_t fifo_q [2];
  logic              wr_ptr_q, wr_ptr_d;
  logic              rd_ptr_q, rd_ptr_d;
  logic [1:0]        cnt_q, cnt_d;
  logic              accept;
  logic              cmd_ok;
  logic              push;
  logic              pop;
  cpim_pkg::q_item_t new_item;

  assign busy_o = (cnt_q == 2'd2);
  assign accept = start_i && !busy_o;

  // Classify the beat; an unknown command is taken and dropped
  always_comb begin
    new_item.value = value_i;
    new_item.last  = last_i;
    new_item.op    = cpim_pkg::OP_APPEND;
    cmd_ok         = 1'b1;
    case (command_i)
      cpim_pkg::CMD_APPEND: new_item.op = cpim_pkg::OP_APPEND;
      cpim_pkg::CMD_CLEAR:  new_item.op = cpim_pkg::OP_CLEAR;
      cpim_pkg::CMD_MAP:    new_item.op = cpim_pkg::OP_MAP;
      default:              cmd_ok      = 1'b0;
    endcase
  end

  assign push = accept && cmd_ok;
  assign pop  = pop_i && (cnt_q != 2'd0);

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ pop;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Hold queued beats
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= new_item;
    end
  end

  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = fifo_q[rd_ptr_q];

  `CPIM_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= 2'd2)
  `CPIM_ASSERT_NXT(a_full_holds, clk_i, rst_ni, busy_o && !pop_i, busy_o)
  `CPIM_ASSERT_IMP(a_pop_has_item, clk_i, rst_ni, pop_i, cnt_q != 2'd0)

endmodule

>>> rtl/cpim_back.sv
// ----------------------------------------------------------------------------
// cpim_back
// Executes queued operations: parent list memory, separator mapping, scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "child_to_parent_index_mapper_top_macros.svh"

module cpim_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cpim_pkg::cfg_t               cfg_i,
  input  logic                         item_valid_i,
  input  cpim_pkg::q_item_t            item_i,
  output logic                         pop_o,
  output logic                         result_valid_o,
  output logic [cpim_pkg::IDX_W-1:0]   parent_index_o,
  output logic                         in_separator_o,
  output logic                         not_found_o,
  output logic [cpim_pkg::HITS_W-1:0]  sep_count_o,
  output logic                         end_of_child_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_CMP  = 3'b100
  } state_e;

  state_e                        state_q, state_d;
  logic [cpim_pkg::LEN_W-1:0]    len_q, len_d;
  logic [cpim_pkg::LEN_W-1:0]    scan_q, scan_d;
  logic                          past_q, past_d;
  logic [cpim_pkg::HITS_W-1:0]   hits_q, hits_d;
  logic [cpim_pkg::IDX_W-1:0]    val_q, val_d;
  logic                          last_q, last_d;
  logic [cpim_pkg::IDX_W-1:0]    rdata_q;
  logic [cpim_pkg::IDX_W-1:0]    mem [cpim_pkg::PARENT_DEPTH];
  logic                          mem_we, mem_re;

  logic                          res_valid_q, res_valid_d;
  logic [cpim_pkg::IDX_W-1:0]    res_pidx_q, res_pidx_d;
  logic                          res_insep_q, res_insep_d;
  logic                          res_nf_q, res_nf_d;
  logic [cpim_pkg::HITS_W-1:0]   res_cnt_q, res_cnt_d;
  logic                          res_eoc_q, res_eoc_d;

  logic [cpim_pkg::HITS_W-1:0]   hits_inc;
  logic [cpim_pkg::IDX_W-1:0]    dsep;
  logic                          scan_found;
  logic                          scan_done;

  assign pop_o    = (state_q == S_IDLE) && item_valid_i;
  assign hits_inc = (hits_q == cpim_pkg::HITS_MAX) ? hits_q
                    : hits_q + cpim_pkg::HITS_W'(1);
  assign dsep     = cfg_i.sep_end - cfg_i.sep_start;

  // Sequence operations and the forward scan
  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    scan_d      = scan_q;
    past_d      = past_q;
    hits_d      = hits_q;
    val_d       = val_q;
    last_d      = last_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    res_valid_d = 1'b0;
    res_pidx_d  = res_pidx_q;
    res_insep_d = res_insep_q;
    res_nf_d    = res_nf_q;
    res_cnt_d   = res_cnt_q;
    res_eoc_d   = res_eoc_q;
    scan_done   = 1'b0;
    scan_found  = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          case (item_i.op)
            cpim_pkg::OP_APPEND: begin
              if (len_q < cpim_pkg::LEN_FULL) begin
                mem_we = 1'b1;
                len_d  = len_q + cpim_pkg::LEN_W'(1);
              end
            end
            cpim_pkg::OP_CLEAR: begin
              len_d  = '0;
              scan_d = '0;
              past_d = 1'b0;
              hits_d = '0;
            end
            cpim_pkg::OP_MAP: begin
              if (!past_q && (item_i.value < cfg_i.sep_end)) begin
                // Separator part: offset from its start, not found below the start
                res_valid_d = 1'b1;
                res_insep_d = 1'b1;
                res_nf_d    = (item_i.value < cfg_i.sep_start);
                res_pidx_d  = (item_i.value < cfg_i.sep_start) ? '0
                              : item_i.value - cfg_i.sep_start;
                res_cnt_d   = hits_inc;
                res_eoc_d   = item_i.last;
                if (item_i.last) begin
                  scan_d = '0;
                  hits_d = '0;
                end else begin
                  hits_d = hits_inc;
                end
              end else begin
                // Update part: start the scan
                past_d  = 1'b1;
                val_d   = item_i.value;
                last_d  = item_i.last;
                state_d = S_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        if (scan_q < len_q) begin
          mem_re  = 1'b1;
          state_d = S_CMP;
        end else begin
          scan_done = 1'b1;
        end
      end
      S_CMP: begin
        if (rdata_q < val_q) begin
          scan_d  = scan_q + cpim_pkg::LEN_W'(1);
          state_d = S_READ;
        end else begin
          scan_done  = 1'b1;
          scan_found = (rdata_q == val_q);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Finish a scanned map
    if (scan_done) begin
      res_valid_d = 1'b1;
      res_insep_d = 1'b0;
      res_nf_d    = !scan_found;
      res_pidx_d  = scan_found ? cpim_pkg::IDX_W'(scan_q) + dsep : '0;
      res_cnt_d   = hits_q;
      res_eoc_d   = last_q;
      state_d     = S_IDLE;
      if (last_q) begin
        scan_d = '0;
        past_d = 1'b0;
        hits_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      scan_q      <= '0;
      past_q      <= 1'b0;
      hits_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      scan_q      <= scan_d;
      past_q      <= past_d;
      hits_q      <= hits_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Hold payload of the scan and the result
  always_ff @(posedge clk_i) begin
    val_q       <= val_d;
    last_q      <= last_d;
    res_pidx_q  <= res_pidx_d;
    res_insep_q <= res_insep_d;
    res_nf_q    <= res_nf_d;
    res_cnt_q   <= res_cnt_d;
    res_eoc_q   <= res_eoc_d;
  end

  // Parent list memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[len_q[cpim_pkg::ADDR_W-1:0]] <= item_i.value;
    end
    if (mem_re) begin
      rdata_q <= mem[scan_q[cpim_pkg::ADDR_W-1:0]];
    end
  end

  assign result_valid_o = res_valid_q;
  assign parent_index_o = res_pidx_q;
  assign in_separator_o = res_insep_q;
  assign not_found_o    = res_nf_q;
  assign sep_count_o    = res_cnt_q;
  assign end_of_child_o = res_eoc_q;

  `CPIM_ASSERT_IMP(a_len_bound, clk_i, rst_ni, 1'b1, len_q <= cpim_pkg::LEN_FULL)
  `CPIM_ASSERT_IMP(a_scan_bound, clk_i, rst_ni, 1'b1, scan_q <= len_q)
  `CPIM_ASSERT_NXT(a_read_to_cmp, clk_i, rst_ni, (state_q == S_READ) && (scan_q < len_q), state_q == S_CMP)
  `CPIM_ASSERT_IMP(a_scan_past, clk_i, rst_ni, state_q != S_IDLE, past_q)

endmodule

>>> rtl/child_to_parent_index_mapper_top.sv
// ----------------------------------------------------------------------------
// child_to_parent_index_mapper_top
// Maps sorted child global indices to local row positions in the parent front.
//
// Channel    | Direction | Handshake                 | Payload
// -----------+-----------+---------------------------+----------------------------
// command    | in        | start_i high, busy_o low  | command_i, value_i, last_i
// result     | out       | result_valid_o one cycle  | parent_index_o, in_separator_o,
//            |           |                           | not_found_o, sep_count_o,
//            |           |                           | end_of_child_o
// config     | in        | cfg_we_i                  | cfg_index_i, cfg_data_i
//
// A two-beat queue parts front and back ends; busy_o is high while the queue is full.
// The back end takes append, clear and separator maps straight from idle; a result strobe
//   follows in the next cycle. A scanned map passes a read and a compare state per parent
//   entry stepped past and ends from either; the list memory has a single registered read port.
// Reset clears length, scan state and configuration; the list memory is not cleared.
// The receiver cannot stall results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module child_to_parent_index_mapper_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [cpim_pkg::CMD_W-1:0]      command_i,
  input  logic [cpim_pkg::IDX_W-1:0]      value_i,
  input  logic                            last_i,
  output logic                            busy_o,
  input  logic                            cfg_we_i,
  input  logic [cpim_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [cpim_pkg::IDX_W-1:0]      cfg_data_i,
  output logic                            result_valid_o,
  output logic [cpim_pkg::IDX_W-1:0]      parent_index_o,
  output logic                            in_separator_o,
  output logic                            not_found_o,
  output logic [cpim_pkg::HITS_W-1:0]     sep_count_o,
  output logic                            end_of_child_o
);

  cpim_pkg::cfg_t    cfg_q;
  cpim_pkg::q_item_t item;
  logic              item_valid;
  logic              pop;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        cpim_pkg::CFG_SEP_START: cfg_q.sep_start <= cfg_data_i;
        cpim_pkg::CFG_SEP_END:   cfg_q.sep_end   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  cpim_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .command_i    (command_i),
    .value_i      (value_i),
    .last_i       (last_i),
    .busy_o       (busy_o),
    .item_valid_o (item_valid),
    .item_o       (item),
    .pop_i        (pop)
  );

  cpim_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .item_valid_i   (item_valid),
    .item_i         (item),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .parent_index_o (parent_index_o),
    .in_separator_o (in_separator_o),
    .not_found_o    (not_found_o),
    .sep_count_o    (sep_count_o),
    .end_of_child_o (end_of_child_o)
  );

endmodule
